// ===== hw/rtl/swi_pkg.sv =====
// ----------------------------------------------------------------------------
// swi_pkg
// Shared widths, kernel codes, controller states and the command bundle of
// the separable window interpolator.
// ----------------------------------------------------------------------------
package swi_pkg;

  // field widths
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int WINDOW      = 4;
  localparam int ROW_FRAC    = 7;
  localparam int ROW_BITS    = SAMPLE_BITS + 8;
  localparam int MODE_BITS   = 3;

  // internal widths: coefficients, horner accumulator, product
  localparam int CW  = ROW_BITS + 5;
  localparam int TW  = CW + 2;
  localparam int PW  = TW + FRAC_BITS + 1;

  // divide by three through a reciprocal, the operand biased to stay positive
  localparam int                   DIV_SHIFT = 33;
  localparam int                   RCP_BITS  = 32;
  localparam int                   DPW       = TW + RCP_BITS;
  localparam logic [RCP_BITS-1:0]  DIV_RECIP = 32'hAAAA_AAAB;
  localparam logic [TW-1:0]        DIV_BIAS  = TW'(3) << (TW - 3);
  localparam logic signed [TW-1:0] DIV_OFS   = TW'(1) << (TW - 3);

  localparam logic [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

  typedef enum logic [MODE_BITS-1:0] {
    KM_NEAREST = 3'd0,
    KM_LINEAR  = 3'd1,
    KM_CUBIC   = 3'd2,
    KM_CATMULL = 3'd3,
    KM_CONV    = 3'd4
  } kernel_e;

  localparam logic [MODE_BITS-1:0] MODE_RESET = KM_LINEAR;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COEF,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_FIN,
    ST_LDCOL
  } state_e;

  typedef struct packed {
    logic       load_row;
    logic       load_col;
    logic       coef;
    logic       mul;
    logic       acc;
    logic       div;
    logic       fin_row;
    logic       fin_col;
    logic [1:0] step;
    kernel_e    mode;
    logic [1:0] row_idx;
  } cmd_t;

  // undefined codes fall back to linear
  function automatic kernel_e eff_mode(input logic [MODE_BITS-1:0] m);
    kernel_e k;
    unique case (m)
      KM_NEAREST: k = KM_NEAREST;
      KM_CUBIC:   k = KM_CUBIC;
      KM_CATMULL: k = KM_CATMULL;
      KM_CONV:    k = KM_CONV;
      default:    k = KM_LINEAR;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/swi_if.sv =====
// ----------------------------------------------------------------------------
// swi_if
// Valid/ready channels of the separable window interpolator: window rows in,
// pixels out.
// ----------------------------------------------------------------------------
interface swi_row_if
  import swi_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_0;
  logic [SAMPLE_BITS-1:0] sample_1;
  logic [SAMPLE_BITS-1:0] sample_2;
  logic [SAMPLE_BITS-1:0] sample_3;
  logic [FRAC_BITS-1:0]   frac_x;
  logic [FRAC_BITS-1:0]   frac_y;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3, frac_x, frac_y,
                  input ready);
  modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, frac_x, frac_y,
                  output ready);
endinterface

interface swi_pix_if
  import swi_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pixel_out;
  logic                   clipped;

  modport source (output valid, pixel_out, clipped, input ready);
  modport sink   (input valid, pixel_out, clipped, output ready);
endinterface

// ===== hw/rtl/swi_ctrl.sv =====
// ----------------------------------------------------------------------------
// swi_ctrl
// Sequencer: steps the shared kernel datapath through each row and, on the
// last row of a window, through the vertical pass.
// ----------------------------------------------------------------------------
module swi_ctrl
  import swi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [MODE_BITS-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cmd_t                 cmd_o
);

  state_e               state_q, state_d;
  logic                 col_q, col_d;
  logic [1:0]           row_count_q, row_count_d;
  logic [1:0]           step_q, step_d;
  logic [MODE_BITS-1:0] mode_q, mode_d;
  logic                 out_valid_q, out_valid_d;

  kernel_e    mode;
  logic [1:0] hsteps;
  logic       last_row;

  assign mode     = eff_mode(mode_q);
  assign last_row = (mode == KM_NEAREST || mode == KM_LINEAR) ? (row_count_q == 2'd1)
                                                              : (row_count_q == 2'd3);

  // horner steps per kernel
  always_comb begin
    unique case (mode)
      KM_NEAREST: hsteps = 2'd0;
      KM_LINEAR:  hsteps = 2'd1;
      default:    hsteps = 2'd3;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= 1'b0;
      row_count_q <= '0;
      step_q      <= '0;
      mode_q      <= MODE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_count_q <= row_count_d;
      step_q      <= step_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_count_d = row_count_q;
    step_d      = step_q;
    mode_d      = mode_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o         = '0;
    cmd_o.mode    = mode;
    cmd_o.step    = step_q;
    cmd_o.row_idx = row_count_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_row = 1'b1;
          state_d        = ST_COEF;
        end
      end
      ST_COEF: begin
        cmd_o.coef = 1'b1;
        step_d     = '0;
        state_d    = (hsteps == 2'd0) ? ST_DIV : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (step_q + 2'd1 == hsteps) begin
          state_d = ST_DIV;
        end else begin
          step_d  = step_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        if (!col_q) begin
          cmd_o.fin_row = 1'b1;
          if (last_row) begin
            row_count_d = '0;
            col_d       = 1'b1;
            state_d     = ST_LDCOL;
          end else begin
            row_count_d = row_count_q + 2'd1;
            state_d     = ST_IDLE;
          end
        end else if (!out_valid_q || out_ready_i) begin
          // output register free or draining this cycle
          cmd_o.fin_col = 1'b1;
          out_valid_d   = 1'b1;
          col_d         = 1'b0;
          state_d       = ST_IDLE;
        end
      end
      ST_LDCOL: begin
        cmd_o.load_col = 1'b1;
        state_d        = ST_COEF;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // kernel change restarts the window
    if (cfg_we_i) begin
      mode_d      = cfg_wdata_i;
      row_count_d = '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/swi_datapath.sv =====
// ----------------------------------------------------------------------------
// swi_datapath
// Shared kernel unit: coefficient former, one horner multiplier, divide by
// three, row buffer and output register.
// ----------------------------------------------------------------------------
module swi_datapath
  import swi_pkg::*;
(
  input  logic                   clk_i,
  input  cmd_t                   cmd_i,
  input  logic [SAMPLE_BITS-1:0] sample_0_i,
  input  logic [SAMPLE_BITS-1:0] sample_1_i,
  input  logic [SAMPLE_BITS-1:0] sample_2_i,
  input  logic [SAMPLE_BITS-1:0] sample_3_i,
  input  logic [FRAC_BITS-1:0]   frac_x_i,
  input  logic [FRAC_BITS-1:0]   frac_y_i,
  output logic [SAMPLE_BITS-1:0] pixel_out_o,
  output logic                   clipped_o
);

  localparam logic signed [TW-1:0] ROW_HI = TW'((1 <<< (ROW_BITS - 1)) - 1);
  localparam logic signed [TW-1:0] ROW_LO = -ROW_HI - TW'(1);
  localparam logic signed [TW-1:0] PIX_HI = TW'((1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [TW-1:0] PIX_LO = -PIX_HI - TW'(1);
  localparam logic signed [TW-1:0] ROW_RND = TW'(1) <<< (ROW_FRAC - 1);
  localparam logic signed [PW-1:0] MUL_RND = PW'(1) <<< (FRAC_BITS - 1);

  logic signed [ROW_BITS-1:0] v_q       [WINDOW];
  logic signed [ROW_BITS-1:0] row_buf_q [WINDOW];
  logic [FRAC_BITS-1:0]       u_q, fy_q;
  logic signed [TW-1:0]       t_q, qa_q;
  logic signed [CW-1:0]       b_q, c_q;
  logic signed [ROW_BITS-1:0] d_q;
  logic signed [PW-1:0]       prod_q;
  logic [DPW-1:0]             dprod_q;
  logic [SAMPLE_BITS-1:0]     pixel_q;
  logic                       clipped_q;

  function automatic logic signed [ROW_BITS-1:0] widen(input logic [SAMPLE_BITS-1:0] s);
    return {{(ROW_BITS - SAMPLE_BITS - ROW_FRAC){s[SAMPLE_BITS-1]}}, s, ROW_FRAC'(0)};
  endfunction

  // coefficient former
  logic signed [CW-1:0]       e0, e1, e2, e3, z1, z2, z3;
  logic signed [CW-1:0]       ca, cb, cc;
  logic signed [ROW_BITS-1:0] cd;

  always_comb begin
    e0 = CW'(v_q[0]);
    e1 = CW'(v_q[1]);
    e2 = CW'(v_q[2]);
    e3 = CW'(v_q[3]);
    z1 = e0 - e1;
    z2 = e2 - e1;
    z3 = e3 - e1;
    ca = '0;
    cb = '0;
    cc = '0;
    cd = v_q[1];
    unique case (cmd_i.mode)
      KM_NEAREST: begin
        cd = (u_q <= FRAC_HALF) ? v_q[0] : v_q[1];
      end
      KM_LINEAR: begin
        ca = e1 - e0;
        cd = v_q[0];
      end
      KM_CUBIC: begin
        ca = -z1 - ((z2 <<< 1) + z2) + z3;
        cb = ((z1 <<< 1) + z1) + ((z2 <<< 1) + z2);
        cc = -(z1 <<< 1) + ((z2 <<< 2) + (z2 <<< 1)) - z3;
      end
      KM_CATMULL: begin
        ca = -e0 + ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3;
        cb = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
        cc = e2 - e0;
      end
      default: begin
        ca = -e0 + e1 - e2 + e3;
        cb = ((e0 - e1) <<< 1) + e2 - e3;
        cc = e2 - e0;
      end
    endcase
  end

  // horner accumulate: round the product, add the next coefficient
  logic signed [PW-1:0] prod_rnd;
  logic signed [CW-1:0] addend;
  logic signed [TW-1:0] acc_t;

  always_comb begin
    prod_rnd = (prod_q + MUL_RND) >>> FRAC_BITS;
    case (cmd_i.step)
      2'd0:    addend = b_q;
      2'd1:    addend = c_q;
      default: addend = '0;
    endcase
    acc_t = prod_rnd[TW-1:0] + TW'(addend);
  end

  // final division by the kernel denominator
  logic signed [TW-1:0] half_t, third_x, q6, qsel, r;
  logic [TW-1:0]        y;
  logic signed [TW-1:0] r_pix;

  always_comb begin
    half_t  = (t_q + TW'(1)) >>> 1;
    third_x = (t_q + TW'(3)) >>> 1;
    y       = $unsigned(third_x) + DIV_BIAS;
    q6      = $signed({1'b0, dprod_q[DIV_SHIFT +: TW-1]}) - DIV_OFS;
    qsel    = (cmd_i.mode == KM_CUBIC) ? q6 : qa_q;
    r       = TW'(d_q) + qsel;
    r_pix   = (r + ROW_RND) >>> ROW_FRAC;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row) begin
      v_q[0] <= widen(sample_0_i);
      v_q[1] <= widen(sample_1_i);
      v_q[2] <= widen(sample_2_i);
      v_q[3] <= widen(sample_3_i);
      u_q    <= frac_x_i;
      fy_q   <= frac_y_i;
    end else if (cmd_i.load_col) begin
      for (int k = 0; k < WINDOW; k++) begin
        v_q[k] <= row_buf_q[k];
      end
      u_q <= fy_q;
    end

    if (cmd_i.coef) begin
      t_q <= TW'(ca);
      b_q <= cb;
      c_q <= cc;
      d_q <= cd;
    end else if (cmd_i.acc) begin
      t_q <= acc_t;
    end

    if (cmd_i.mul) begin
      prod_q <= t_q * $signed({1'b0, u_q});
    end

    if (cmd_i.div) begin
      qa_q    <= (cmd_i.mode == KM_CATMULL) ? half_t : t_q;
      dprod_q <= y * DIV_RECIP;
    end

    if (cmd_i.fin_row) begin
      if (r > ROW_HI) begin
        row_buf_q[cmd_i.row_idx] <= ROW_HI[ROW_BITS-1:0];
      end else if (r < ROW_LO) begin
        row_buf_q[cmd_i.row_idx] <= ROW_LO[ROW_BITS-1:0];
      end else begin
        row_buf_q[cmd_i.row_idx] <= r[ROW_BITS-1:0];
      end
    end

    if (cmd_i.fin_col) begin
      if (r_pix > PIX_HI) begin
        pixel_q   <= PIX_HI[SAMPLE_BITS-1:0];
        clipped_q <= 1'b1;
      end else if (r_pix < PIX_LO) begin
        pixel_q   <= PIX_LO[SAMPLE_BITS-1:0];
        clipped_q <= 1'b1;
      end else begin
        pixel_q   <= r_pix[SAMPLE_BITS-1:0];
        clipped_q <= 1'b0;
      end
    end
  end

  assign pixel_out_o = pixel_q;
  assign clipped_o   = clipped_q;

endmodule

// ===== hw/rtl/separable_window_interpolator.sv =====
// ----------------------------------------------------------------------------
// separable_window_interpolator
// Separable 2-D resampling of a pixel window: each row interpolated
// horizontally, then the buffered row results vertically, one pixel a window.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake        carries
//  row_i      in   valid/ready      sample_0..3, frac_x, frac_y (one window row)
//  pix_o      out  valid/ready      pixel_out, clipped (one per window)
//  cfg        in   cfg_we_i         kernel_mode, no read-back
//
//  a row item runs through coefficients, multiply/accumulate per horner step,
//  divide and finish in the shared kernel unit, which has a single multiplier
//  for the horner steps; the last row of a window then runs the vertical pass
//  a new row is taken only in idle; a finished pixel waits in the output
//  register, so rows keep flowing while pix_o stalls, until the next pixel
//  reset clears the sequencer, the row counter and sets the kernel to linear
//
module separable_window_interpolator
  import swi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [MODE_BITS-1:0] cfg_wdata_i,
  swi_row_if.sink              row_i,
  swi_pix_if.source            pix_o
);

  cmd_t cmd;

  // sequencer: handshakes, row counting, kernel register
  swi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (row_i.valid),
    .in_ready_o  (row_i.ready),
    .out_valid_o (pix_o.valid),
    .out_ready_i (pix_o.ready),
    .cmd_o       (cmd)
  );

  // kernel arithmetic, row buffer and pixel register
  swi_datapath u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .sample_0_i  (row_i.sample_0),
    .sample_1_i  (row_i.sample_1),
    .sample_2_i  (row_i.sample_2),
    .sample_3_i  (row_i.sample_3),
    .frac_x_i    (row_i.frac_x),
    .frac_y_i    (row_i.frac_y),
    .pixel_out_o (pix_o.pixel_out),
    .clipped_o   (pix_o.clipped)
  );

endmodule
